/* sv/pin_change_debounce_rotary_defines.svh */
`ifndef PIN_CHANGE_DEBOUNCE_ROTARY_DEFINES_SVH
`define PIN_CHANGE_DEBOUNCE_ROTARY_DEFINES_SVH

// check that holds in the same cycle as its condition
`define PCDR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check that holds in the cycle after its condition
`define PCDR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pcdr_pkg.sv */
`timescale 1ns / 1ps

package pcdr_pkg;

   // port geometry
   localparam int PORT_PINS  = 8;
   localparam int PIN_W      = $clog2(PORT_PINS);
   localparam int MS_W       = 8;
   localparam int CNT_W      = 3;
   localparam int DELTA_W    = CNT_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = PORT_PINS * PIN_W;

   // request queue between front and back, power of two
   localparam int QUEUE_DEPTH = 2;

   localparam logic [MS_W-1:0] DEBOUNCE_MS_RESET = 8'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REGISTERED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTARY      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTARY_B    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTNER     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS = 3'd5;

   // request operations
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_SERVICE = 1'b1;

   // result kinds
   localparam logic KIND_CHANGE = 1'b0;
   localparam logic KIND_ROTARY = 1'b1;

   typedef struct packed {
      logic [PORT_PINS-1:0]  registered;
      logic [PORT_PINS-1:0]  debounce;
      logic [PORT_PINS-1:0]  rotary;
      logic [PORT_PINS-1:0]  rotary_b;
      logic [CSR_DATA_W-1:0] partner;
      logic [MS_W-1:0]       debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic                 op;
      logic [PORT_PINS-1:0] levels;
      logic [MS_W-1:0]      millis;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic                      kind;
      logic [PIN_W-1:0]          pin;
      logic                      level;
      logic signed [DELTA_W-1:0] delta;
   } result_type;

endpackage

/* sv/pin_change_debounce_rotary.sv */
`timescale 1ns / 1ps

// Pin change detector with debounce lockout and rotary detent counting.
// Request channel (req_*): func 0 gives a new sample of the 8 pin levels,
// func 1 runs a service pass (lockout expiry, change scan, rotary report).
// Response channel (rsp_*): change events and rotary delta reports, lowest
// pin first within each walk; rsp_last marks the final response of a
// request. A request that causes nothing gives no response.
// Both channels use valid/stall; a request is taken when req_valid is high
// and req_stall low. A two-entry queue decouples request intake from the
// pin sequencer, so requests are taken while responses wait.
// The sequencer walks one pin per clock unless the response output blocks it:
// a sample runs a scan and a change walk; a service pass adds an expiry walk
// before and, when a detent was counted, a report walk after. Responses leave
// one per cycle at most.
// While rsp_stall is high the pending response holds and the sequencer waits
// on its next response; the queue keeps accepting until full.
// Configuration is written through csr_* with one write per cycle, by the
// user only while idle; the block does not enforce it. Sync reset clears
// config and pin state bar lockout stamps; debounce time resets to 10 ms.
module pin_change_debounce_rotary (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [pcdr_pkg::PORT_PINS-1:0]         req_pin_levels,
   input  logic [pcdr_pkg::MS_W-1:0]              req_millis_low,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_kind,
   output logic [pcdr_pkg::PIN_W-1:0]             rsp_pin_index,
   output logic                                   rsp_pin_level,
   output logic signed [pcdr_pkg::DELTA_W-1:0]    rsp_rotary_delta,
   output logic                                   rsp_last,
   input  logic                                   csr_wr_en,
   input  logic [pcdr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pcdr_pkg::CSR_DATA_W-1:0]        csr_wr_data
);

   localparam int PINS = pcdr_pkg::PORT_PINS;

   // register values after reset
   localparam pcdr_pkg::cfg_type CFG_RESET = '{
      registered:  '0,
      debounce:    '0,
      rotary:      '0,
      rotary_b:    '0,
      partner:     '0,
      debounce_ms: pcdr_pkg::DEBOUNCE_MS_RESET
   };

   pcdr_pkg::cfg_type       cfg_ff, cfg_in;
   pcdr_pkg::queue_out_type q_head;
   logic                    q_pop;
   pcdr_pkg::result_type    rsp_result;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pcdr_pkg::CSR_REGISTERED:  cfg_in.registered  = csr_wr_data[PINS-1:0];
            pcdr_pkg::CSR_DEBOUNCE:    cfg_in.debounce    = csr_wr_data[PINS-1:0];
            pcdr_pkg::CSR_ROTARY:      cfg_in.rotary      = csr_wr_data[PINS-1:0];
            pcdr_pkg::CSR_ROTARY_B:    cfg_in.rotary_b    = csr_wr_data[PINS-1:0];
            pcdr_pkg::CSR_PARTNER:     cfg_in.partner     = csr_wr_data;
            pcdr_pkg::CSR_DEBOUNCE_MS: cfg_in.debounce_ms = csr_wr_data[pcdr_pkg::MS_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request intake and queue
   pcdr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_pin_levels (req_pin_levels),
      .req_millis_low (req_millis_low),
      .q_out          (q_head),
      .q_pop          (q_pop)
   );

   // pin sequencer and response register
   pcdr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_in       (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_last)
   );

   assign rsp_kind         = rsp_result.kind;
   assign rsp_pin_index    = rsp_result.pin;
   assign rsp_pin_level    = rsp_result.level;
   assign rsp_rotary_delta = rsp_result.delta;

endmodule

/* sv/pcdr_front.sv */
`timescale 1ns / 1ps

module pcdr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [pcdr_pkg::PORT_PINS-1:0]     req_pin_levels,
   input  logic [pcdr_pkg::MS_W-1:0]          req_millis_low,
   output pcdr_pkg::queue_out_type            q_out,
   input  logic                               q_pop
);

   localparam int PTR_W = $clog2(pcdr_pkg::QUEUE_DEPTH);

   pcdr_pkg::item_type slot_ff [pcdr_pkg::QUEUE_DEPTH];
   pcdr_pkg::item_type new_item;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               accept;

   // classify the request
   always_comb begin
      new_item.op     = req_func ? pcdr_pkg::OP_SERVICE : pcdr_pkg::OP_SAMPLE;
      new_item.levels = req_pin_levels;
      new_item.millis = req_millis_low;
   end

   assign req_stall = (count_ff == (PTR_W + 1)'(pcdr_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !q_pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (!accept && q_pop) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = slot_ff[rd_ptr_ff];

endmodule

/* sv/pcdr_back.sv */
`timescale 1ns / 1ps
`include "pin_change_debounce_rotary_defines.svh"

module pcdr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pcdr_pkg::cfg_type        cfg,
   input  pcdr_pkg::queue_out_type  q_in,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pcdr_pkg::result_type     rsp_result,
   output logic                     rsp_last
);

   localparam int PIN_W = pcdr_pkg::PIN_W;
   localparam int PINS  = pcdr_pkg::PORT_PINS;
   localparam int CNT_W = pcdr_pkg::CNT_W;
   localparam int MS_W  = pcdr_pkg::MS_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPIRE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_CHANGE = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;
   localparam logic [2:0] ST_FLUSH  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [PIN_W-1:0]           pin_ff, pin_in;
   pcdr_pkg::item_type         item_ff, item_in;
   logic [PINS-1:0]            changed_ff, changed_in;
   logic [PINS-1:0]            prev_ff, prev_in;
   logic [PINS-1:0]            locked_ff, locked_in;
   logic [PINS-1:0]            expect_ff, expect_in;
   logic [PINS-1:0][CNT_W-1:0] count_ff, count_in;
   logic                       turned_ff, turned_in;
   logic [MS_W-1:0]            stamp_ff [PINS];
   logic                       held_valid_ff, held_valid_in;
   pcdr_pkg::result_type       held_ff, held_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   pcdr_pkg::result_type       rsp_ff, rsp_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [PIN_W-1:0]           partner_raw, partner;
   logic                       pin_last;
   logic [MS_W-1:0]            stamp_rd, elapsed;
   logic                       expire_hit, replay, act;
   logic [PINS-1:0]            cp;
   logic                       level, olevel;
   logic                       emit, flush, push, blocked, push_go, stamp_we;
   pcdr_pkg::result_type       emit_res;
   logic signed [pcdr_pkg::DELTA_W-1:0] delta;

   // partner lookup, an index beyond the port means the pin itself
   always_comb begin
      partner_raw = cfg.partner[pin_ff * PIN_W +: PIN_W];
      partner     = partner_raw;
      if ({1'b0, partner_raw} >= (PIN_W + 1)'(PINS)) begin
         partner = pin_ff;
      end
   end

   assign pin_last = (pin_ff == PIN_W'(PINS - 1));
   assign stamp_rd = stamp_ff[pin_ff];
   assign elapsed  = item_ff.millis - stamp_rd;

   // select what the current pin step acts on
   always_comb begin
      expire_hit = 1'b0;
      replay     = 1'b0;
      act        = 1'b0;
      cp         = item_ff.levels;
      case (state_ff)
         ST_EXPIRE: begin
            expire_hit = locked_ff[pin_ff] && (elapsed >= cfg.debounce_ms);
            replay     = expire_hit && (item_ff.levels[pin_ff] != prev_ff[pin_ff])
                         && cfg.registered[pin_ff];
            act        = replay;
            cp         = prev_ff;
            cp[pin_ff] = ~prev_ff[pin_ff];
         end
         ST_CHANGE: begin
            act = changed_ff[pin_ff];
         end
         default: begin
            act = 1'b0;
         end
      endcase
   end

   assign level  = cp[pin_ff];
   assign olevel = cp[partner];
   assign delta  = pcdr_pkg::DELTA_W'({1'b0, count_ff[partner]})
                   - pcdr_pkg::DELTA_W'({1'b0, count_ff[pin_ff]});

   // sequencer: one pin per cycle unless the output blocks the step
   always_comb begin
      state_in      = state_ff;
      pin_in        = pin_ff;
      item_in       = item_ff;
      changed_in    = changed_ff;
      prev_in       = prev_ff;
      locked_in     = locked_ff;
      expect_in     = expect_ff;
      count_in      = count_ff;
      turned_in     = turned_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      stamp_we      = 1'b0;
      emit          = 1'b0;
      flush         = 1'b0;
      q_pop         = 1'b0;
      emit_res      = '0;

      // lockout ran out, replay a missed change
      if (expire_hit) begin
         locked_in[pin_ff] = 1'b0;
      end
      if (replay) begin
         prev_in[pin_ff] = ~prev_ff[pin_ff];
      end

      // pin change action
      if (act) begin
         if (cfg.rotary[pin_ff]) begin
            if (level && olevel && expect_ff[pin_ff]) begin
               expect_in[pin_ff]  = 1'b0;
               expect_in[partner] = 1'b0;
               count_in[pin_ff]   = count_ff[pin_ff] + CNT_W'(1);
               turned_in          = 1'b1;
            end else if (level && !olevel) begin
               expect_in[partner] = 1'b1;
            end
         end else begin
            if (cfg.debounce[pin_ff]) begin
               locked_in[pin_ff] = 1'b1;
               stamp_we          = 1'b1;
            end
            emit           = 1'b1;
            emit_res.kind  = pcdr_pkg::KIND_CHANGE;
            emit_res.pin   = pin_ff;
            emit_res.level = level;
            emit_res.delta = '0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_in.valid) begin
               q_pop    = 1'b1;
               item_in  = q_in.item;
               pin_in   = '0;
               state_in = (q_in.item.op == pcdr_pkg::OP_SERVICE) ? ST_EXPIRE : ST_SCAN;
            end
         end
         ST_EXPIRE: begin
            pin_in = pin_ff + PIN_W'(1);
            if (pin_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            changed_in = (item_ff.levels ^ prev_ff) & cfg.registered & ~locked_ff;
            prev_in    = prev_ff ^ changed_in;
            pin_in     = '0;
            state_in   = ST_CHANGE;
         end
         ST_CHANGE: begin
            pin_in = pin_ff + PIN_W'(1);
            if (pin_last) begin
               if (item_ff.op == pcdr_pkg::OP_SERVICE && turned_in) begin
                  turned_in = 1'b0;
                  state_in  = ST_REPORT;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_REPORT: begin
            // a-side pins report the count difference to their partner
            if (cfg.rotary[pin_ff] && !cfg.rotary_b[pin_ff] && delta != '0) begin
               count_in[pin_ff]  = '0;
               count_in[partner] = '0;
               emit              = 1'b1;
               emit_res.kind     = pcdr_pkg::KIND_ROTARY;
               emit_res.pin      = pin_ff;
               emit_res.level    = 1'b0;
               emit_res.delta    = delta;
            end
            pin_in = pin_ff + PIN_W'(1);
            if (pin_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            flush    = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one result is held back so the final one can carry last
      push    = (emit || flush) && held_valid_ff;
      blocked = push && rsp_valid_ff && rsp_stall;
      push_go = push && !blocked;

      if (emit) begin
         held_valid_in = 1'b1;
         held_in       = emit_res;
      end
      if (flush) begin
         held_valid_in = 1'b0;
      end

      // output full, hold the whole step
      if (blocked) begin
         state_in      = state_ff;
         pin_in        = pin_ff;
         item_in       = item_ff;
         changed_in    = changed_ff;
         prev_in       = prev_ff;
         locked_in     = locked_ff;
         expect_in     = expect_ff;
         count_in      = count_ff;
         turned_in     = turned_ff;
         held_valid_in = held_valid_ff;
         held_in       = held_ff;
         stamp_we      = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rsp_last_in  = rsp_last_ff;
      if (push_go) begin
         rsp_valid_in = 1'b1;
         rsp_in       = held_ff;
         rsp_last_in  = flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pin_ff        <= '0;
         prev_ff       <= '0;
         locked_ff     <= '0;
         expect_ff     <= '0;
         count_ff      <= '0;
         turned_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pin_ff        <= pin_in;
         prev_ff       <= prev_in;
         locked_ff     <= locked_in;
         expect_ff     <= expect_in;
         count_ff      <= count_in;
         turned_ff     <= turned_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      changed_ff  <= changed_in;
      held_ff     <= held_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // lockout stamps
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_ff[pin_ff] <= item_ff.millis;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign rsp_last   = rsp_last_ff;

   `PCDR_ASSERT_NOW(a_push_room, push_go && rsp_valid_ff, !rsp_stall, "result overwritten")
   `PCDR_ASSERT_NOW(a_idle_empty, state_ff == ST_IDLE, !held_valid_ff, "held result left over")
   `PCDR_ASSERT_NEXT(a_flush_done, state_ff == ST_FLUSH && !blocked, state_ff == ST_IDLE,
                     "flush did not finish")
   `PCDR_ASSERT_NOW(a_pop_valid, q_pop, q_in.valid, "pop from empty queue")

endmodule
